@@ src/ptd_pkg.sv @@
`default_nettype none

package ptd_pkg;

   localparam int unsigned SCREEN_OFFSET_X = 40;
   localparam int unsigned ROW_BYTES       = 52;

   localparam int unsigned LUMA_R_WEIGHT    = 77;
   localparam int unsigned LUMA_G_WEIGHT    = 150;
   localparam int unsigned LUMA_B_WEIGHT    = 29;
   localparam int unsigned LUMA_BLACK_LIMIT = 64;
   localparam int unsigned SEG_THR_BASE     = 224;
   localparam int unsigned SEG2_SCALE       = 85;
   localparam int unsigned SEG4_SCALE       = 17;
   localparam int unsigned SEG_INV_LIMIT    = 31;
   localparam int unsigned BIT_MASK_MSB     = 'h80;

   // reciprocals: exact for x < 2^17/27 (div 31) and x < 2^20/59 (div 63)
   localparam int unsigned RECIP31       = 4229;
   localparam int unsigned RECIP31_SHIFT = 17;
   localparam int unsigned RECIP63       = 16645;
   localparam int unsigned RECIP63_SHIFT = 20;

   localparam logic [3:0] DITHER_MATRIX [16] = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5
   };

   localparam logic [1:0] FMT_8BIT = 2'd0;
   localparam logic [1:0] FMT_4BIT = 2'd1;
   localparam logic [1:0] FMT_2BIT = 2'd2;

   localparam logic CSR_SEGMENT_FORMAT = 1'b0;
   localparam logic CSR_INVERTED       = 1'b1;

   localparam logic KIND_BACKGROUND = 1'b0;
   localparam logic KIND_SEGMENT    = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] pixel_value;
      logic [1:0]  sub_index;
      logic [8:0]  src_x;
      logic [7:0]  src_y;
   } req_type;

   typedef struct packed {
      logic        black;
      logic [13:0] byte_index;
      logic [7:0]  bit_mask;
   } rsp_type;

   typedef struct packed {
      logic [1:0] segment_format;
      logic       inverted;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [11:0] r_prod;
      logic [13:0] g_prod;
      logic [9:0]  b_prod;
      logic [7:0]  seg_val;
      logic [7:0]  seg_thr;
      logic        inverted;
      logic [13:0] row_base;
      logic [9:0]  col;
   } s1_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  r_quot;
      logic [8:0]  g_quot;
      logic [7:0]  b_quot;
      logic        seg_black;
      logic [13:0] byte_index;
      logic [7:0]  bit_mask;
   } s2_type;

   function automatic logic [7:0] div31(input logic [11:0] x);
      logic [24:0] p;
      p = 25'(x) * 25'(RECIP31);
      return 8'(p >> RECIP31_SHIFT);
   endfunction

   function automatic logic [8:0] div63(input logic [13:0] x);
      logic [28:0] p;
      p = 29'(x) * 29'(RECIP63);
      return 9'(p >> RECIP63_SHIFT);
   endfunction

endpackage

`default_nettype wire

@@ src/ptd_csr.sv @@
`default_nettype none

module ptd_csr
   import ptd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [1:0] csr_data,
   output cfg_type         cfg
);

   logic [1:0] segment_format_ff, segment_format_in;
   logic       inverted_ff, inverted_in;

   assign csr_ready = 1'b1;

   always_comb begin
      segment_format_in = segment_format_ff;
      inverted_in       = inverted_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SEGMENT_FORMAT: segment_format_in = csr_data;
            CSR_INVERTED:       inverted_in       = csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_format_ff <= FMT_8BIT;
         inverted_ff       <= 1'b0;
      end else begin
         segment_format_ff <= segment_format_in;
         inverted_ff       <= inverted_in;
      end
   end

   assign cfg.segment_format = segment_format_ff;
   assign cfg.inverted       = inverted_ff;

endmodule

`default_nettype wire

@@ src/ptd_unpack_stage.sv @@
`default_nettype none

module ptd_unpack_stage
   import ptd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire req_type in_data,
   input  wire cfg_type cfg,
   output logic         out_valid,
   output s1_type       out_data
);

   logic       valid_ff;
   s1_type     data_ff, data_in;
   logic [7:0] seg_byte;
   logic [7:0] crumb_shift;
   logic [3:0] nibble;
   logic [3:0] dither;

   always_comb begin
      seg_byte    = in_data.pixel_value[7:0];
      crumb_shift = seg_byte >> {in_data.sub_index, 1'b0};
      nibble      = in_data.sub_index[0] ? seg_byte[3:0] : seg_byte[7:4];
      dither      = DITHER_MATRIX[{in_data.src_y[1:0], in_data.src_x[1:0]}];

      data_in.kind   = in_data.kind;
      data_in.r_prod = 12'(in_data.pixel_value[15:11]) * 12'(LUMA_R_WEIGHT);
      data_in.g_prod = 14'(in_data.pixel_value[10:5]) * 14'(LUMA_G_WEIGHT);
      data_in.b_prod = 10'(in_data.pixel_value[4:0]) * 10'(LUMA_B_WEIGHT);

      unique case (cfg.segment_format)
         FMT_2BIT: data_in.seg_val = 8'(crumb_shift[1:0]) * 8'(SEG2_SCALE);
         FMT_4BIT: data_in.seg_val = 8'(nibble) * 8'(SEG4_SCALE);
         default:  data_in.seg_val = seg_byte;   // unused code 3 acts as 8-bit
      endcase

      data_in.seg_thr  = 8'(SEG_THR_BASE) + {3'b000, dither, 1'b0};
      data_in.inverted = cfg.inverted;
      data_in.row_base = 14'(in_data.src_y) * 14'(ROW_BYTES);
      data_in.col      = 10'(SCREEN_OFFSET_X) + 10'(in_data.src_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ src/ptd_divide_stage.sv @@
`default_nettype none

module ptd_divide_stage
   import ptd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire s1_type in_data,
   output logic        out_valid,
   output s2_type      out_data
);

   logic   valid_ff;
   s2_type data_ff, data_in;

   always_comb begin
      data_in.kind       = in_data.kind;
      data_in.r_quot     = div31(in_data.r_prod);
      data_in.g_quot     = div63(in_data.g_prod);
      data_in.b_quot     = div31(12'(in_data.b_prod));
      data_in.seg_black  = in_data.inverted ? (in_data.seg_val > 8'(SEG_INV_LIMIT))
                                            : (in_data.seg_val < in_data.seg_thr);
      data_in.byte_index = in_data.row_base + 14'(in_data.col[9:3]);
      data_in.bit_mask   = 8'(BIT_MASK_MSB) >> in_data.col[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ src/ptd_resolve_stage.sv @@
`default_nettype none

module ptd_resolve_stage
   import ptd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire s2_type in_data,
   output logic        out_valid,
   output rsp_type     out_data
);

   logic       valid_ff;
   rsp_type    data_ff, data_in;
   logic [9:0] luma;

   always_comb begin
      luma = 10'(in_data.r_quot) + 10'(in_data.g_quot) + 10'(in_data.b_quot);
      data_in.black      = (in_data.kind == KIND_SEGMENT) ? in_data.seg_black
                                                          : (luma < 10'(LUMA_BLACK_LIMIT));
      data_in.byte_index = in_data.byte_index;
      data_in.bit_mask   = in_data.bit_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ src/pixel_threshold_dither_1bit_unit.sv @@
// Channel   Handshake             Payload
// req       start / busy          req_data  (kind, pixel_value, sub_index, src_x, src_y)
// rsp       rsp_valid (strobe)    rsp_data  (black, byte_index, bit_mask)
// csr       csr_valid / csr_ready csr_index, csr_data
//
// Three register stages: multiply/unpack, reciprocal divide, luma sum and select.
// One pixel per clock while busy is low; results pass the unpack, divide and resolve
// registers before the strobe. busy is high only while reset is held; the pipeline
// never stalls since the receiver takes every result. Synchronous reset clears valid
// bits and CSR registers (segment_format = 8-bit, inverted = 0). csr_ready is tied high.
`default_nettype none

module pixel_threshold_dither_1bit_unit
   import ptd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [1:0] csr_data
);

   cfg_type cfg;
   logic    s1_valid, s2_valid;
   s1_type  s1_data;
   s2_type  s2_data;

   assign busy = reset;

   ptd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ptd_unpack_stage u_unpack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (s1_valid),
      .out_data  (s1_data)
   );

   ptd_divide_stage u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   ptd_resolve_stage u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy, 3))
      else $error("result strobe does not match start beat three cycles earlier");

   a_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_data.bit_mask))
      else $error("bit mask not one-hot");

   a_mask_follows_col: assert property (@(posedge clock) disable iff (reset)
      s2_valid |-> (s2_data.bit_mask == (8'(BIT_MASK_MSB) >> $past(s1_data.col[2:0]))))
      else $error("bit mask does not follow screen column");

endmodule

`default_nettype wire
